// ===== hw/rtl/dashboard_segment_frame_encoder_assert.svh =====
// ----------------------------------------------------------------------------
// Dashboard segment frame encoder - assertion macros
// Shared concurrent assertion forms; clocked on the rising edge, held off
// while reset is high.
// ----------------------------------------------------------------------------
`ifndef DASHBOARD_SEGMENT_FRAME_ENCODER_ASSERT_SVH
`define DASHBOARD_SEGMENT_FRAME_ENCODER_ASSERT_SVH

// same-cycle implication
`define DSFE_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dsfe: same-cycle check failed");

// next-cycle implication
`define DSFE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dsfe: next-cycle check failed");

`endif

// ===== hw/rtl/dsfe_pkg.sv =====
// ----------------------------------------------------------------------------
// Dashboard segment frame encoder package
// Frame size, register indexes, status bundle and digit helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package dsfe_pkg;

   // frame length in bytes (valid range 14 to 16)
   localparam int unsigned FRAME_BYTES = 16;
   localparam int unsigned IDX_W       = 4;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES - 1);

   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned CSR_DATA_W = 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LEFT_STEADY  = 1'b0,
      CSR_RIGHT_STEADY = 1'b1
   } csr_idx_type;

   // status flags carried along the pipe with the digits
   typedef struct packed {
      logic       left_turn;
      logic       near_light;
      logic [2:0] fault_flags;
      logic       braked;
      logic [3:0] battery_level;
      logic       mileage_blink;
      logic       speed_blink;
      logic [2:0] gear_mode;
   } status_type;

   localparam logic [7:0] SEG_DIGIT [10] = '{
      8'h3F, 8'h30, 8'h6D, 8'h79, 8'h72, 8'h5B, 8'h5F, 8'h31, 8'h7F, 8'h7B
   };
   localparam logic [7:0] SEG_POINT = 8'h80;
   localparam logic [7:0] SEG_MASK  = 8'h7F;
   localparam logic [7:0] BAT_AREA  = 8'h7F;

   // decimal digit from the low nibbles of floor(n/10^i) and floor(n/10^(i+1))
   function automatic logic [3:0] digit_val(input logic [3:0] q_lo,
                                            input logic [3:0] q_next);
      return 4'(q_lo - 4'(q_next * 4'd10));
   endfunction

   function automatic logic [7:0] seg_of(input logic [3:0] d);
      logic [7:0] s;
      case (d)
         4'd0, 4'd1, 4'd2, 4'd3, 4'd4,
         4'd5, 4'd6, 4'd7, 4'd8, 4'd9: s = SEG_DIGIT[d];
         default:                      s = 8'h00;
      endcase
      return s;
   endfunction

   function automatic logic [7:0] bar_mask(input logic [3:0] lvl);
      logic [7:0] m;
      case (lvl)
         4'd1:    m = 8'h01;
         4'd2:    m = 8'h03;
         4'd3:    m = 8'h07;
         4'd4:    m = 8'h0F;
         4'd5:    m = 8'h1F;
         4'd6:    m = 8'h3F;
         4'd7:    m = 8'h7F;
         4'd8:    m = 8'hFF;
         default: m = 8'h00;
      endcase
      return m;
   endfunction

   function automatic logic [3:0] gear_icon(input logic [2:0] g);
      logic [3:0] ic;
      case (g)
         3'd1:    ic = 4'b0001;
         3'd2:    ic = 4'b0010;
         3'd3:    ic = 4'b0100;
         3'd4:    ic = 4'b1000;
         default: ic = 4'b0000;
      endcase
      return ic;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/dashboard_segment_frame_encoder.sv =====
// ----------------------------------------------------------------------------
// Dashboard segment frame encoder
// Turns one vehicle status request into a segment frame, sent a byte a time.
// ----------------------------------------------------------------------------
// Pipeline: three register stages (request, quotients, frame store); the
//   first byte of a frame is offered once the frame is in the last stage.
// Flow: the byte serialiser holds a frame until its last byte is taken;
//   the two stages ahead of it hold up to two more requests.
// Reset: synchronous, active high; clears the pipe, blink phase, byte
//   counter and the steady bit. No memory clearing pass.
`default_nettype none

module dashboard_segment_frame_encoder
   import dsfe_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,

   input  wire logic                  req_valid,
   output      logic                  req_ready,
   input  wire logic                  req_left_turn,
   input  wire logic                  req_right_turn,
   input  wire logic                  req_near_light,
   input  wire logic [2:0]            req_fault_flags,
   input  wire logic                  req_braked,
   input  wire logic [3:0]            req_battery_level,
   input  wire logic signed [15:0]    req_temperature,
   input  wire logic [23:0]           req_mileage,
   input  wire logic [7:0]            req_speed,
   input  wire logic                  req_mileage_blink,
   input  wire logic                  req_speed_blink,
   input  wire logic [2:0]            req_gear_mode,

   output      logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   output      logic [IDX_W-1:0]      rsp_byte_index,
   output      logic [7:0]            rsp_segment_byte,
   output      logic                  rsp_last_byte
);

   // ------------------------------------------------------------------
   // Reciprocals for the constant divisions. For an n of W bits,
   // K = W + clog2(d) and M = ceil(2^K / d) give floor(n*M >> K) = n/d
   // exactly. Only the low nibble of each quotient is kept: a digit is
   // q_i - 10*q_(i+1), which is 0..9, so mod-16 arithmetic is enough.
   // ------------------------------------------------------------------
   localparam int unsigned MW  = 24;
   localparam int unsigned TW  = 16;
   localparam int unsigned SW  = 8;
   localparam int unsigned MPW = 2 * MW + 5;
   localparam int unsigned TPW = 2 * TW + 5;
   localparam int unsigned SPW = 2 * SW + 5;

   localparam int unsigned MK1 = MW + $clog2(10);
   localparam int unsigned MK2 = MW + $clog2(100);
   localparam int unsigned MK3 = MW + $clog2(1000);
   localparam int unsigned MK4 = MW + $clog2(10000);
   localparam int unsigned MK5 = MW + $clog2(100000);
   localparam logic [63:0] MM1 = ((64'd1 << MK1) + 64'd9) / 64'd10;
   localparam logic [63:0] MM2 = ((64'd1 << MK2) + 64'd99) / 64'd100;
   localparam logic [63:0] MM3 = ((64'd1 << MK3) + 64'd999) / 64'd1000;
   localparam logic [63:0] MM4 = ((64'd1 << MK4) + 64'd9999) / 64'd10000;
   localparam logic [63:0] MM5 = ((64'd1 << MK5) + 64'd99999) / 64'd100000;

   localparam int unsigned TK1 = TW + $clog2(10);
   localparam int unsigned TK2 = TW + $clog2(100);
   localparam int unsigned TK3 = TW + $clog2(1000);
   localparam logic [63:0] TM1 = ((64'd1 << TK1) + 64'd9) / 64'd10;
   localparam logic [63:0] TM2 = ((64'd1 << TK2) + 64'd99) / 64'd100;
   localparam logic [63:0] TM3 = ((64'd1 << TK3) + 64'd999) / 64'd1000;

   localparam int unsigned SK1 = SW + $clog2(10);
   localparam int unsigned SK2 = SW + $clog2(100);
   localparam logic [63:0] SM1 = ((64'd1 << SK1) + 64'd9) / 64'd10;
   localparam logic [63:0] SM2 = ((64'd1 << SK2) + 64'd99) / 64'd100;

   // ------------------------------------------------------------------
   // Configuration. Only the left steady bit is kept: byte 3 is always
   // overwritten by byte 2, so the right indicator never shows.
   // ------------------------------------------------------------------
   logic left_steady_ff, left_steady_in;

   always_comb begin
      left_steady_in = left_steady_ff;
      if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_LEFT_STEADY:  left_steady_in = csr_wdata[0];
            CSR_RIGHT_STEADY: left_steady_in = left_steady_ff;
            default:          left_steady_in = left_steady_ff;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Pipe handshake: stage A (request), stage B (quotients),
   // stage C (frame store and serialiser).
   // ------------------------------------------------------------------
   logic a_vld_ff, b_vld_ff, c_vld_ff;
   logic load_a, load_b, load_c;
   logic rsp_take, c_free;
   logic [IDX_W-1:0] idx_ff;

   assign rsp_take  = c_vld_ff && rsp_ready;
   assign c_free    = !c_vld_ff || (rsp_take && (idx_ff == LAST_IDX));
   assign load_c    = b_vld_ff && c_free;
   assign load_b    = a_vld_ff && (!b_vld_ff || load_c);
   assign req_ready = !a_vld_ff || load_b;
   assign load_a    = req_valid && req_ready;

   // ------------------------------------------------------------------
   // Stage A: request register; temperature folded to its magnitude
   // ------------------------------------------------------------------
   status_type  stat_a_ff, stat_a_in;
   logic [MW-1:0] mile_a_ff;
   logic [TW-1:0] mag_a_ff, mag_a_in;
   logic [SW-1:0] spd_a_ff;

   always_comb begin
      stat_a_in.left_turn     = req_left_turn;
      stat_a_in.near_light    = req_near_light;
      stat_a_in.fault_flags   = req_fault_flags;
      stat_a_in.braked        = req_braked;
      stat_a_in.battery_level = req_battery_level;
      stat_a_in.mileage_blink = req_mileage_blink;
      stat_a_in.speed_blink   = req_speed_blink;
      stat_a_in.gear_mode     = req_gear_mode;
      // -32768 maps to 0x8000, which still fits unsigned
      mag_a_in = req_temperature[15] ? TW'(-req_temperature) : TW'(req_temperature);
   end

   always_ff @(posedge clock) begin
      if (load_a) begin
         stat_a_ff <= stat_a_in;
         mile_a_ff <= req_mileage;
         mag_a_ff  <= mag_a_in;
         spd_a_ff  <= req_speed;
      end
   end

   // ------------------------------------------------------------------
   // Stage B: one reciprocal multiply per quotient, in parallel
   // ------------------------------------------------------------------
   logic [MPW-1:0] mp1, mp2, mp3, mp4, mp5;
   logic [TPW-1:0] tp1, tp2, tp3;
   logic [SPW-1:0] sp1, sp2;

   assign mp1 = MPW'(mile_a_ff) * MPW'(MM1);
   assign mp2 = MPW'(mile_a_ff) * MPW'(MM2);
   assign mp3 = MPW'(mile_a_ff) * MPW'(MM3);
   assign mp4 = MPW'(mile_a_ff) * MPW'(MM4);
   assign mp5 = MPW'(mile_a_ff) * MPW'(MM5);
   assign tp1 = TPW'(mag_a_ff) * TPW'(TM1);
   assign tp2 = TPW'(mag_a_ff) * TPW'(TM2);
   assign tp3 = TPW'(mag_a_ff) * TPW'(TM3);
   assign sp1 = SPW'(spd_a_ff) * SPW'(SM1);
   assign sp2 = SPW'(spd_a_ff) * SPW'(SM2);

   status_type stat_b_ff;
   logic [3:0] mq_ff [6];   // mileage / 10^i, low nibble
   logic [3:0] tq_ff [3];   // magnitude / 10^(i+1), low nibble
   logic [3:0] sq_ff [3];   // speed / 10^i, low nibble

   always_ff @(posedge clock) begin
      if (load_b) begin
         stat_b_ff <= stat_a_ff;
         mq_ff[0]  <= mile_a_ff[3:0];
         mq_ff[1]  <= mp1[MK1 +: 4];
         mq_ff[2]  <= mp2[MK2 +: 4];
         mq_ff[3]  <= mp3[MK3 +: 4];
         mq_ff[4]  <= mp4[MK4 +: 4];
         mq_ff[5]  <= mp5[MK5 +: 4];
         tq_ff[0]  <= tp1[TK1 +: 4];
         tq_ff[1]  <= tp2[TK2 +: 4];
         tq_ff[2]  <= tp3[TK3 +: 4];
         sq_ff[0]  <= spd_a_ff[3:0];
         sq_ff[1]  <= sp1[SK1 +: 4];
         sq_ff[2]  <= sp2[SK2 +: 4];
      end
   end

   // ------------------------------------------------------------------
   // Stage C: blink phase steps as a frame is composed; off is phase 0..4
   // ------------------------------------------------------------------
   logic [3:0] phase_ff, phase_in;
   logic       off;
   logic       mblank, sblank, left_on;
   logic [7:0] frame_c [16];

   always_comb begin
      phase_in = (phase_ff == 4'd9) ? 4'd0 : 4'(phase_ff + 4'd1);
      off      = phase_in < 4'd5;
      mblank   = stat_b_ff.mileage_blink && off;
      sblank   = stat_b_ff.speed_blink && off;
      left_on  = stat_b_ff.left_turn && (left_steady_ff || !off);

      // temperature tens and hundreds
      frame_c[0] = seg_of(digit_val(tq_ff[0], tq_ff[1])) | SEG_POINT;
      frame_c[1] = seg_of(digit_val(tq_ff[1], tq_ff[2]))
                 | (stat_b_ff.near_light ? SEG_POINT : 8'h00);
      // speed ones (left indicator point), mirrored; speed tens, mirrored
      frame_c[2] = seg_of(digit_val(sq_ff[0], sq_ff[1]))
                 | (left_on ? SEG_POINT : 8'h00);
      frame_c[4] = seg_of(digit_val(sq_ff[1], sq_ff[2])) | SEG_POINT;
      if (sblank) begin
         frame_c[2] = frame_c[2] & SEG_MASK;
         frame_c[4] = frame_c[4] & SEG_MASK;
      end
      frame_c[3] = frame_c[2];
      frame_c[5] = frame_c[4];
      // mileage, ten-thousands down to ones
      frame_c[6]  = seg_of(digit_val(mq_ff[4], mq_ff[5])) | SEG_POINT;
      frame_c[7]  = seg_of(digit_val(mq_ff[3], mq_ff[4]));
      frame_c[8]  = seg_of(digit_val(mq_ff[2], mq_ff[3]));
      frame_c[9]  = seg_of(digit_val(mq_ff[1], mq_ff[2]));
      frame_c[10] = seg_of(digit_val(mq_ff[0], mq_ff[1]));
      if (mblank) begin
         frame_c[0] = frame_c[0] & SEG_MASK;
         frame_c[1] = frame_c[1] & SEG_MASK;
         frame_c[6] = frame_c[6] & SEG_MASK;
      end
      // battery bars and area; empty battery blinks the area
      frame_c[11] = bar_mask(stat_b_ff.battery_level);
      frame_c[12] = ((stat_b_ff.battery_level == 4'd0) && off) ? 8'h00 : BAT_AREA;
      // brake, faults, gear icons
      frame_c[13] = {stat_b_ff.braked, stat_b_ff.fault_flags,
                     gear_icon(stat_b_ff.gear_mode)};
      frame_c[14] = 8'h00;
      frame_c[15] = 8'h00;
   end

   logic [7:0] frame_ff [FRAME_BYTES];

   always_ff @(posedge clock) begin
      if (load_c) begin
         for (int k = 0; k < FRAME_BYTES; k++) begin
            frame_ff[k] <= frame_c[k];
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff       <= 1'b0;
         b_vld_ff       <= 1'b0;
         c_vld_ff       <= 1'b0;
         idx_ff         <= '0;
         phase_ff       <= 4'd0;
         left_steady_ff <= 1'b0;
      end else begin
         left_steady_ff <= left_steady_in;
         if (load_a) begin
            a_vld_ff <= 1'b1;
         end else if (load_b) begin
            a_vld_ff <= 1'b0;
         end
         if (load_b) begin
            b_vld_ff <= 1'b1;
         end else if (load_c) begin
            b_vld_ff <= 1'b0;
         end
         if (load_c) begin
            c_vld_ff <= 1'b1;
            idx_ff   <= '0;
            phase_ff <= phase_in;
         end else if (rsp_take) begin
            if (idx_ff == LAST_IDX) begin
               c_vld_ff <= 1'b0;
               idx_ff   <= '0;
            end else begin
               idx_ff <= IDX_W'(idx_ff + 1'b1);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Response: the byte under the counter
   // ------------------------------------------------------------------
   assign rsp_valid        = c_vld_ff;
   assign rsp_byte_index   = idx_ff;
   assign rsp_segment_byte = frame_ff[idx_ff];
   assign rsp_last_byte    = (idx_ff == LAST_IDX);

   // ------------------------------------------------------------------
   // Checks
   // ------------------------------------------------------------------
`include "dashboard_segment_frame_encoder_assert.svh"

   `DSFE_ASSERT_NEXT(a_phase_step, clock, reset, load_c,
      phase_ff == (($past(phase_ff) == 4'd9) ? 4'd0 : 4'($past(phase_ff) + 4'd1)))
   `DSFE_ASSERT_NEXT(a_byte_advance, clock, reset, rsp_take && !rsp_last_byte,
      rsp_valid && (rsp_byte_index == 4'($past(rsp_byte_index) + 1'b1)))
   `DSFE_ASSERT_NEXT(a_frame_start, clock, reset, load_c,
      rsp_valid && (rsp_byte_index == '0))
   `DSFE_ASSERT_NOW(a_no_overwrite, clock, reset, load_c && c_vld_ff,
      rsp_take && rsp_last_byte)

endmodule

`default_nettype wire
